/* sv/lefc_pkg.sv */
// Shared types, constants and mask tables for the LED eye frame composer.
`timescale 1ns / 1ps

package lefc_pkg;

    // Frame geometry: two LEDs per memory row, one in each bank
    localparam int LED_COUNT = 128;
    localparam int ROW_COUNT = LED_COUNT / 2;
    localparam int ROW_W     = $clog2(ROW_COUNT);

    localparam int COLOR_W  = 24;
    localparam int BRIGHT_W = 5;
    localparam int MASK_W   = 4;
    localparam int WORD_W   = 32;

    localparam logic [7:0]          HEADER_BASE = 8'hE0;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX  = 5'd31;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MIN  = 5'd1;
    localparam logic [MASK_W-1:0]   MASK_COUNT  = 4'd11;
    localparam logic [MASK_W-1:0]   MASK_RESET  = 4'd1;
    localparam logic [COLOR_W-1:0]  FG_RESET    = 24'h808080;
    localparam logic [COLOR_W-1:0]  BG_RESET    = 24'h000000;

    // Input and output word widths
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [2:0] {
        OP_BRIGHTER = 3'd0,
        OP_DIMMER   = 3'd1,
        OP_SET_ONE  = 3'd2,
        OP_SET_ALL  = 3'd3,
        OP_SELECT   = 3'd4
    } t_opcode;

    // Configuration register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    typedef enum logic [1:0] {
        FLIP_NONE = 2'd0,
        FLIP_COLS = 2'd1,
        FLIP_ROWS = 2'd2,
        FLIP_BOTH = 2'd3
    } t_flip;

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic [COLOR_W-1:0]  color;
    } t_entry;

    localparam t_entry RESET_ENTRY = '{bright: BRIGHT_MIN, color: '0};

    typedef struct packed {
        logic             we_even;
        logic             we_odd;
        logic [ROW_W-1:0] addr;
        t_entry           data_even;
        t_entry           data_odd;
    } t_mem_wr;

    typedef struct packed {
        logic idle;
        logic writing;
    } t_seq_stat;

    typedef struct packed {
        logic [3:0] pic_a;
        t_flip      flip_a;
        logic [3:0] pic_b;
        t_flip      flip_b;
    } t_choice;

    // Per-mask bitmap and flip choice for each eye
    function automatic t_choice lefc_choice(input logic [MASK_W-1:0] mask);
        t_choice c;
        begin
            case (mask)
                4'd0:    c = '{4'd0, FLIP_NONE, 4'd0, FLIP_NONE};
                4'd1:    c = '{4'd1, FLIP_NONE, 4'd1, FLIP_NONE};
                4'd2:    c = '{4'd2, FLIP_NONE, 4'd2, FLIP_NONE};
                4'd3:    c = '{4'd3, FLIP_NONE, 4'd3, FLIP_NONE};
                4'd4:    c = '{4'd3, FLIP_ROWS, 4'd3, FLIP_ROWS};
                4'd5:    c = '{4'd4, FLIP_NONE, 4'd4, FLIP_NONE};
                4'd6:    c = '{4'd5, FLIP_NONE, 4'd5, FLIP_ROWS};
                4'd7:    c = '{4'd6, FLIP_NONE, 4'd6, FLIP_NONE};
                4'd8:    c = '{4'd7, FLIP_NONE, 4'd7, FLIP_NONE};
                4'd9:    c = '{4'd7, FLIP_ROWS, 4'd7, FLIP_ROWS};
                4'd10:   c = '{4'd8, FLIP_NONE, 4'd8, FLIP_NONE};
                default: c = '{4'd0, FLIP_NONE, 4'd0, FLIP_NONE};
            endcase
            return c;
        end
    endfunction

    // 8x8 bitmaps, one byte per row, leftmost column in the top bit
    function automatic logic [7:0] lefc_bitmap_row(input logic [3:0] pic,
                                                   input logic [2:0] row);
        logic [63:0] bm;
        begin
            case (pic)
                4'd0:    bm = 64'hFFFFFFFF_FFFFFFFF;
                4'd1:    bm = 64'h003C7E66_667E3C00;
                4'd2:    bm = 64'h0000007E_7E000000;
                4'd3:    bm = 64'h00004266_7E3C1800;
                4'd4:    bm = 64'h81C3663C_3C66C381;
                4'd5:    bm = 64'h40607038_1C0E0602;
                4'd6:    bm = 64'h007E7E18_18181800;
                4'd7:    bm = 64'h00666666_667E3C00;
                4'd8:    bm = 64'h3C42A581_A599423C;
                default: bm = '0;
            endcase
            return bm[(7 - row) * 8 +: 8];
        end
    endfunction

    // Mask pixel at a frame position: upper half is eye b, rows run bottom up
    function automatic logic lefc_pixel_on(input logic [MASK_W-1:0] mask,
                                           input logic [ROW_W:0]    pos);
        t_choice    c;
        logic [3:0] pic;
        t_flip      flip;
        logic [2:0] row;
        logic [2:0] col;
        logic [2:0] r;
        logic [2:0] cc;
        logic [7:0] bits;
        begin
            c    = lefc_choice(mask);
            pic  = pos[ROW_W] ? c.pic_b  : c.pic_a;
            flip = pos[ROW_W] ? c.flip_b : c.flip_a;
            row  = ~pos[5:3];
            col  = pos[2:0];
            r    = (flip == FLIP_NONE || flip == FLIP_COLS) ? row : ~row;
            cc   = (flip == FLIP_NONE || flip == FLIP_ROWS) ? col : ~col;
            bits = lefc_bitmap_row(pic, r);
            return bits[~cc];
        end
    endfunction

    // LED word: header byte with brightness, then the colour
    function automatic logic [WORD_W-1:0] lefc_led_word(input t_entry e);
        logic [7:0] hdr;
        begin
            hdr = HEADER_BASE + {3'b000, e.bright};
            return {hdr, e.color};
        end
    endfunction

endpackage

/* sv/lefc_frame_mem.sv */
// Two-bank frame memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module lefc_frame_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lefc_pkg::t_mem_wr         i_wr,
    input  logic [lefc_pkg::ROW_W-1:0] i_rd_addr,
    output lefc_pkg::t_entry          o_rd_even,
    output lefc_pkg::t_entry          o_rd_odd
);
    import lefc_pkg::*;

    t_entry               r_mem_even [ROW_COUNT];
    t_entry               r_mem_odd  [ROW_COUNT];
    logic [ROW_COUNT-1:0] r_vld_even;
    logic [ROW_COUNT-1:0] r_vld_odd;
    t_entry               r_rd_even;
    t_entry               r_rd_odd;
    logic                 r_rd_ve;
    logic                 r_rd_vo;

    // Write and read both banks
    always_ff @(posedge i_clk) begin
        if (i_wr.we_even) begin
            r_mem_even[i_wr.addr] <= i_wr.data_even;
        end
        if (i_wr.we_odd) begin
            r_mem_odd[i_wr.addr] <= i_wr.data_odd;
        end
        r_rd_even <= r_mem_even[i_rd_addr];
        r_rd_odd  <= r_mem_odd[i_rd_addr];
    end

    // Mark written entries; unwritten ones read as the reset entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_even <= '0;
            r_vld_odd  <= '0;
            r_rd_ve    <= 1'b0;
            r_rd_vo    <= 1'b0;
        end else begin
            if (i_wr.we_even) begin
                r_vld_even[i_wr.addr] <= 1'b1;
            end
            if (i_wr.we_odd) begin
                r_vld_odd[i_wr.addr] <= 1'b1;
            end
            r_rd_ve <= r_vld_even[i_rd_addr];
            r_rd_vo <= r_vld_odd[i_rd_addr];
        end
    end

    assign o_rd_even = r_rd_ve ? r_rd_even : RESET_ENTRY;
    assign o_rd_odd  = r_rd_vo ? r_rd_odd  : RESET_ENTRY;

endmodule

/* sv/lefc_seq.sv */
// Command sequencer: decodes commands, redraws the frame, streams it out.
`timescale 1ns / 1ps

module lefc_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_addr,
    input  logic [lefc_pkg::COLOR_W-1:0]    i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [lefc_pkg::IN_TDATA_W-1:0] i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [lefc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    output lefc_pkg::t_mem_wr               o_wr,
    output logic [lefc_pkg::ROW_W-1:0]      o_rd_addr,
    input  lefc_pkg::t_entry                i_rd_even,
    input  lefc_pkg::t_entry                i_rd_odd,
    output lefc_pkg::t_seq_stat             o_stat
);
    import lefc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_LOAD,
        S_SEND
    } t_state;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

    t_state              r_state;
    logic [ROW_W-1:0]    r_cnt;
    logic [BRIGHT_W-1:0] r_bright;
    logic [MASK_W-1:0]   r_mask;
    logic [COLOR_W-1:0]  r_fg;
    logic [COLOR_W-1:0]  r_bg;
    logic                r_fill_all;
    logic [COLOR_W-1:0]  r_fill_color;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_even;
    logic [WORD_W-1:0]   r_odd;
    logic                r_last;

    t_opcode             w_op;
    logic [ROW_W:0]      w_idx;
    logic [COLOR_W-1:0]  w_color;
    logic [MASK_W-1:0]   w_sel;
    logic                w_accept;
    t_entry              w_fg_entry;
    t_entry              w_bg_entry;

    // Unpack the command word
    assign w_op     = t_opcode'(i_s_tdata[2:0]);
    assign w_idx    = i_s_tdata[9:3];
    assign w_color  = i_s_tdata[33:10];
    assign w_sel    = i_s_tdata[37:34];
    assign w_accept = i_s_tvalid && (r_state == S_IDLE);

    assign w_fg_entry = '{bright: r_bright, color: r_fg};
    assign w_bg_entry = '{bright: r_bright, color: r_bg};

    // Hold colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FG:  r_fg <= i_cfg_wdata;
                CFG_BG:  r_bg <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Drive memory writes: one row per cycle for redraws and set-all, one entry for set-one
    always_comb begin
        o_wr = '0;
        if (r_state == S_WRITE) begin
            o_wr.we_even = 1'b1;
            o_wr.we_odd  = 1'b1;
            o_wr.addr    = r_cnt;
            if (r_fill_all) begin
                o_wr.data_even = '{bright: r_bright, color: r_fill_color};
                o_wr.data_odd  = '{bright: r_bright, color: r_fill_color};
            end else begin
                o_wr.data_even = lefc_pixel_on(r_mask, {r_cnt, 1'b0}) ? w_fg_entry
                                                                       : w_bg_entry;
                o_wr.data_odd  = lefc_pixel_on(r_mask, {r_cnt, 1'b1}) ? w_fg_entry
                                                                       : w_bg_entry;
            end
        end else if (w_accept && w_op == OP_SET_ONE) begin
            o_wr.we_even   = ~w_idx[0];
            o_wr.we_odd    = w_idx[0];
            o_wr.addr      = w_idx[ROW_W:1];
            o_wr.data_even = '{bright: r_bright, color: w_color};
            o_wr.data_odd  = '{bright: r_bright, color: w_color};
        end
    end

    // Read ahead by one row while the current pair is on offer
    assign o_rd_addr = (r_state == S_SEND) ? r_cnt + ROW_W'(1) : r_cnt;

    // Advance the sequencer and hold the output pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_bright    <= BRIGHT_MIN;
            r_mask      <= MASK_RESET;
            r_fill_all  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt <= '0;
                        case (w_op)
                            OP_BRIGHTER: begin
                                if (r_bright != BRIGHT_MAX) begin
                                    r_bright <= r_bright + BRIGHT_W'(1);
                                end
                                r_fill_all <= 1'b0;
                                r_state    <= S_WRITE;
                            end
                            OP_DIMMER: begin
                                if (r_bright != BRIGHT_MIN) begin
                                    r_bright <= r_bright - BRIGHT_W'(1);
                                end
                                r_fill_all <= 1'b0;
                                r_state    <= S_WRITE;
                            end
                            OP_SET_ONE: begin
                                r_state <= S_READ;
                            end
                            OP_SET_ALL: begin
                                r_fill_all   <= 1'b1;
                                r_fill_color <= w_color;
                                r_state      <= S_WRITE;
                            end
                            OP_SELECT: begin
                                // drop a mask number past the table
                                if (w_sel < MASK_COUNT) begin
                                    r_mask     <= w_sel;
                                    r_fill_all <= 1'b0;
                                    r_state    <= S_WRITE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WRITE: begin
                    if (r_cnt == ROW_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_READ;
                    end else begin
                        r_cnt <= r_cnt + ROW_W'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_even      <= lefc_led_word(i_rd_even);
                    r_odd       <= lefc_led_word(i_rd_odd);
                    r_last      <= (r_cnt == ROW_LAST);
                    r_out_valid <= 1'b1;
                    r_state     <= S_SEND;
                end
                S_SEND: begin
                    if (i_m_tready) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + ROW_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready     = (r_state == S_IDLE);
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = {r_odd, r_even};
    assign o_m_tlast      = r_last;
    assign o_stat.idle    = (r_state == S_IDLE);
    assign o_stat.writing = (r_state == S_WRITE);

endmodule

/* sv/led_eye_mask_frame_composer.sv */
// Top level of the LED eye frame composer: sequencer plus frame memory.
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         opcode[2:0] pixel_index[9:3] pixel_color[33:10] mask_select[37:34]
//  m_axis    out        even_word[31:0] odd_word[63:32], tlast on the final pair
//  i_cfg_*   in         register 0 fg_color, register 1 bg_color
//
// A redraw (brighter, dimmer, select mask) or set-all writes 64 memory rows, one
// per cycle, two LEDs per row; set-one writes one entry as the command is taken.
// Streaming then reads one row per pair through the registered memory read,
// loading each pair before it is offered and holding it while m_axis_tready is low.
// Reset is synchronous; the frame reads as brightness 1, colour 0 at once.
// A new command is taken only after the last pair of the frame is taken.
`timescale 1ns / 1ps

module led_eye_mask_frame_composer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic                             i_cfg_addr,
    input  logic [lefc_pkg::COLOR_W-1:0]     i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // opcode, pixel_index, pixel_color, mask_select, zero pad
    input  logic [lefc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // even_word, odd_word
    output logic [lefc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tlast
);
    import lefc_pkg::*;

    t_mem_wr          w_wr;
    logic [ROW_W-1:0] w_rd_addr;
    t_entry           w_rd_even;
    t_entry           w_rd_odd;
    t_seq_stat        w_stat;

    lefc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast),
        .o_wr        (w_wr),
        .o_rd_addr   (w_rd_addr),
        .i_rd_even   (w_rd_even),
        .i_rd_odd    (w_rd_odd),
        .o_stat      (w_stat)
    );

    lefc_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_even (w_rd_even),
        .o_rd_odd  (w_rd_odd)
    );

`ifndef SYNTHESIS
    // A command is never taken while a pair is on offer
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("command ready while output pair pending");

    // Frame writes finish before streaming starts
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr.we_even || w_wr.we_odd) |-> !m_axis_tvalid)
        else $error("frame write during streaming");

    // Redraw sweep keeps the block busy
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.writing |-> !w_stat.idle && !s_axis_tready)
        else $error("ready during frame redraw");

    // Taking the final pair returns the block to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not idle after last pair");
`endif

endmodule
